[rtl/pil_pkg.sv]
`timescale 1ns / 1ps

package pil_pkg;

  // Width of the data word ports
  localparam int unsigned PORT_DW = 32;

  // Operation codes carried by each input item
  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_POP    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_ERASE  = 3'd3,
    MODE_READ   = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNDER = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ERASE  = 2'd2
  } cell_cmd_t;

endpackage

[rtl/pil_cell.sv]
`timescale 1ns / 1ps

module pil_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 5,
  parameter int unsigned DW  = 32
) (
  input  logic              clk,
  input  pil_pkg::cell_cmd_t cmd,
  input  logic [PW-1:0]     pos,
  input  logic [DW-1:0]     load_word,
  input  logic [DW-1:0]     left_word,
  input  logic [DW-1:0]     right_word,
  output logic [DW-1:0]     word,
  output logic [DW-1:0]     sel_word
);

  logic          at_pos;
  logic          above_pos;
  logic [DW-1:0] word_next;

  assign at_pos    = (PW'(IDX) == pos);
  assign above_pos = (PW'(IDX) > pos);

  // Pick the new content: load, take from a neighbor, or hold
  always_comb begin
    word_next = word;
    case (cmd)
      pil_pkg::CELL_INSERT: begin
        if (at_pos) begin
          word_next = load_word;
        end else if (above_pos) begin
          word_next = left_word;
        end
      end
      pil_pkg::CELL_ERASE: begin
        if (at_pos || above_pos) begin
          word_next = right_word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // Drive the word onto the read bus only when addressed
  assign sel_word = at_pos ? word : '0;

endmodule

[rtl/positional_insert_erase_list_top.sv]
`timescale 1ns / 1ps

// Fixed-capacity ordered list held in a chain of CAPACITY cells, one data word
// per cell. Each item (append, remove last, insert, erase, read, clear) is
// applied in the cycle it is accepted: insert and erase move every later word
// one cell up or down in that same cycle, so items may follow back to back.
// The result (read value, status, count) is registered in an output register;
// a new item is taken whenever that register is empty or being emptied. Read
// values come from a one-hot select across all cells. No clearing pass follows
// reset: only the element count and out_valid are reset.
module positional_insert_erase_list_top #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      mode,
  input  logic [$clog2(CAPACITY+1)-1:0]   position,
  input  logic [pil_pkg::PORT_DW-1:0]     value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pil_pkg::PORT_DW-1:0]     read_value,
  output logic [1:0]                      status,
  output logic [$clog2(CAPACITY+1)-1:0]   count
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = (DATA_WIDTH < pil_pkg::PORT_DW) ? DATA_WIDTH : pil_pkg::PORT_DW;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic                 accept;
  logic [CW-1:0]        elem_cnt;
  logic [CW-1:0]        elem_cnt_next;
  pil_pkg::cell_cmd_t   cmd;
  logic [CW-1:0]        cmd_pos;
  pil_pkg::status_t     st;
  logic                 do_read;
  logic [SW-1:0]        load_word;
  logic [SW-1:0]        words  [CAPACITY];
  logic [SW-1:0]        sel    [CAPACITY];
  logic [SW-1:0]        rd_word;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign load_word = value[SW-1:0];

  // Decode the item into a chain command and a status
  always_comb begin
    cmd           = pil_pkg::CELL_HOLD;
    cmd_pos       = position;
    st            = pil_pkg::ST_OK;
    do_read       = 1'b0;
    elem_cnt_next = elem_cnt;
    case (pil_pkg::mode_t'(mode))
      pil_pkg::MODE_APPEND: begin
        if (elem_cnt >= CAP) begin
          st = pil_pkg::ST_FULL;
        end else begin
          cmd           = pil_pkg::CELL_INSERT;
          cmd_pos       = elem_cnt;
          elem_cnt_next = elem_cnt + 1'b1;
        end
      end
      pil_pkg::MODE_POP: begin
        if (elem_cnt == '0) begin
          st = pil_pkg::ST_UNDER;
        end else begin
          elem_cnt_next = elem_cnt - 1'b1;
        end
      end
      pil_pkg::MODE_INSERT: begin
        if (position > elem_cnt) begin
          st = pil_pkg::ST_RANGE;
        end else if (elem_cnt >= CAP) begin
          st = pil_pkg::ST_FULL;
        end else begin
          cmd           = pil_pkg::CELL_INSERT;
          elem_cnt_next = elem_cnt + 1'b1;
        end
      end
      pil_pkg::MODE_ERASE: begin
        if (position >= elem_cnt) begin
          st = pil_pkg::ST_RANGE;
        end else begin
          cmd           = pil_pkg::CELL_ERASE;
          elem_cnt_next = elem_cnt - 1'b1;
        end
      end
      pil_pkg::MODE_READ: begin
        if (position >= elem_cnt) begin
          st = pil_pkg::ST_RANGE;
        end else begin
          do_read = 1'b1;
        end
      end
      pil_pkg::MODE_CLEAR: begin
        elem_cnt_next = '0;
      end
      default: begin
        st = pil_pkg::ST_OK;
      end
    endcase
    if (!accept) begin
      cmd = pil_pkg::CELL_HOLD;
    end
  end

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SW-1:0] left_w;
    logic [SW-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    pil_cell #(
      .IDX (i),
      .PW  (CW),
      .DW  (SW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (cmd_pos),
      .load_word  (load_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i]),
      .sel_word   (sel[i])
    );
  end

  // Merge the one-hot read bus
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_word = rd_word | sel[k];
    end
  end

  // Hold the count and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        elem_cnt  <= elem_cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= do_read ? pil_pkg::PORT_DW'(rd_word) : '0;
      status     <= st;
      count      <= elem_cnt_next;
    end
  end

endmodule

[rtl/pil_chk.sv]
`timescale 1ns / 1ps

module pil_chk #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pil_pkg::PORT_DW-1:0]   read_value,
  input logic [1:0]                    status,
  input logic [$clog2(CAPACITY+1)-1:0] count
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Count never exceeds the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count <= CW'(CAPACITY)))
    else $error("count above capacity");

  // Full only when the list is at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == pil_pkg::ST_FULL) |-> (count == CW'(CAPACITY)))
    else $error("full status with room left");

  // Underflow only on an empty list
  a_under_cnt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == pil_pkg::ST_UNDER) |-> (count == '0))
    else $error("underflow status with elements held");

  // A nonzero read value only comes with ok status
  a_rd_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_value != '0) |-> (status == pil_pkg::ST_OK))
    else $error("read value on failed item");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(read_value) && $stable(status) && $stable(count)))
    else $error("stalled result changed");

endmodule

bind positional_insert_erase_list_top pil_chk #(
  .CAPACITY (CAPACITY)
) u_pil_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_value (read_value),
  .status     (status),
  .count      (count)
);

[tb/positional_insert_erase_list_top_tb.sv]
`timescale 1ns / 1ps

module positional_insert_erase_list_top_tb;

  localparam int unsigned LIST_CAP = 16;
  localparam int unsigned POS_W = $clog2(LIST_CAP + 1);
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int unsigned RAND_ITEMS = 1510;
  localparam int unsigned STALL_CYCLES = 150;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  count;
  } list_result_t;

  typedef struct {
    logic [2:0]       op;
    logic [POS_W-1:0] pos;
    logic [31:0]      word;
    int unsigned      reps;
    bit               typed;
    list_result_t     want;
  } plan_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [2:0]       mode;
  logic [POS_W-1:0] position;
  logic [31:0]      value;
  logic             out_valid;
  logic             out_ready;
  logic [31:0]      read_value;
  logic [1:0]       status;
  logic [POS_W-1:0] count;

  // Shadow copy of the list
  logic [31:0]  list_words [LIST_CAP];
  int unsigned  list_len;

  list_result_t result_q [$];
  bit           cur_typed;
  list_result_t cur_want;

  // Directed stimulus table
  plan_row_t    plan [$];

  bit quiet_phase;
  bit stall_req;
  bit stall_done;

  int unsigned errors;
  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned full_hits;
  int unsigned range_hits;
  int unsigned under_hits;

  positional_insert_erase_list_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_value(read_value),
    .status    (status),
    .count     (count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one operation to the shadow list and return its result
  function automatic list_result_t apply_list_op(logic [2:0] op, logic [POS_W-1:0] pos,
                                                 logic [31:0] word);
    list_result_t res;
    int unsigned  p;
    int unsigned  i;
    res.read_value = '0;
    res.status     = pil_pkg::ST_OK;
    p = pos;
    case (op)
      pil_pkg::MODE_APPEND: begin
        if (list_len >= LIST_CAP) begin
          res.status = pil_pkg::ST_FULL;
        end else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      pil_pkg::MODE_POP: begin
        if (list_len == 0) res.status = pil_pkg::ST_UNDER;
        else list_len--;
      end
      pil_pkg::MODE_INSERT: begin
        // position past the end wins over full
        if (p > list_len) begin
          res.status = pil_pkg::ST_RANGE;
        end else if (list_len >= LIST_CAP) begin
          res.status = pil_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_words[i] = list_words[i - 1];
          list_words[p] = word;
          list_len++;
        end
      end
      pil_pkg::MODE_ERASE: begin
        if (p >= list_len) begin
          res.status = pil_pkg::ST_RANGE;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      pil_pkg::MODE_READ: begin
        if (p >= list_len) res.status = pil_pkg::ST_RANGE;
        else res.read_value = list_words[p];
      end
      pil_pkg::MODE_CLEAR: list_len = 0;
      default: ;
    endcase
    res.count = list_len[4:0];
    return res;
  endfunction

  function automatic list_result_t mk_result(logic [31:0] rv, logic [1:0] st, logic [4:0] cnt);
    list_result_t r;
    r.read_value = rv;
    r.status     = st;
    r.count      = cnt;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(logic [2:0] op, logic [POS_W-1:0] pos, logic [31:0] word,
                                  int unsigned reps, bit typed, list_result_t want);
    plan_row_t row;
    row.op    = op;
    row.pos   = pos;
    row.word  = word;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    plan.insert(plan.size(), row);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Score results against the oldest expectation, then record newly taken items
  always @(posedge clk) begin
    list_result_t want;
    list_result_t pred;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual %h/%0d/%0d",
                   $time, read_value, status, count);
        end else begin
          want = result_q.pop_front();
          check_field("read_value", want.read_value, read_value);
          check_field("status", {30'd0, want.status}, {30'd0, status});
          check_field("count", {27'd0, want.count}, {27'd0, count});
          results_seen++;
        end
      end
      if (in_valid && in_ready) begin
        pred = apply_list_op(mode, position, value);
        if (pred.status == pil_pkg::ST_FULL) full_hits++;
        if (pred.status == pil_pkg::ST_RANGE) range_hits++;
        if (pred.status == pil_pkg::ST_UNDER) under_hits++;
        result_q.insert(result_q.size(), cur_typed ? cur_want : pred);
        items_taken++;
      end
    end
  end

  // Offer one item at the falling edge and hold it until taken
  task automatic offer_item(logic [2:0] op, logic [POS_W-1:0] pos, logic [31:0] word,
                            bit typed, list_result_t want);
    while (!quiet_phase && !(stall_req && !stall_done) && $urandom_range(0, 99) < 38) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    mode      = op;
    position  = pos;
    value     = word;
    cur_typed = typed;
    cur_want  = want;
    in_valid  = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mode mix shifts between growing, shrinking and mixed traffic
  function automatic logic [2:0] pick_op(int unsigned phase);
    int unsigned r;
    int unsigned c_app, c_ins, c_pop, c_era, c_rd, c_clr;
    r = $urandom_range(0, 99);
    case (phase)
      0: begin c_app = 35; c_ins = 60; c_pop = 68; c_era = 76; c_rd = 92; c_clr = 94; end
      1: begin c_app = 10; c_ins = 20; c_pop = 50; c_era = 80; c_rd = 95; c_clr = 97; end
      default: begin c_app = 20; c_ins = 40; c_pop = 55; c_era = 70; c_rd = 95; c_clr = 97; end
    endcase
    if (r < c_app) return pil_pkg::MODE_APPEND;
    if (r < c_ins) return pil_pkg::MODE_INSERT;
    if (r < c_pop) return pil_pkg::MODE_POP;
    if (r < c_era) return pil_pkg::MODE_ERASE;
    if (r < c_rd) return pil_pkg::MODE_READ;
    if (r < c_clr) return pil_pkg::MODE_CLEAR;
    if (r < 99) return MODE_SPARE6;
    return MODE_SPARE7;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return POS_W'($urandom_range(0, list_len));
    if (r < 80) return POS_W'((list_len == 0) ? 0 : list_len - 1);
    return POS_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h0000_0000;
    if (r < 10) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req && !stall_done) begin
        out_ready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        stall_done = 1'b1;
      end else begin
        out_ready = quiet_phase || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  // Run limit
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    plan_row_t    row;
    list_result_t none;
    logic [2:0]   op;
    int unsigned  rand_done;
    int unsigned  k;

    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = pil_pkg::MODE_APPEND;
    position    = '0;
    value       = '0;
    cur_typed   = 1'b0;
    list_len    = 0;
    quiet_phase = 1'b0;
    stall_req   = 1'b0;
    stall_done  = 1'b0;
    none        = mk_result('0, pil_pkg::ST_OK, '0);
    cur_want    = none;

    // Directed table: empty list, extremes, full list, ignored modes, clear
    add_row(pil_pkg::MODE_POP, 5'd0, 32'h0, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_UNDER, 5'd0));
    add_row(pil_pkg::MODE_READ, 5'd0, 32'h0, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_RANGE, 5'd0));
    add_row(pil_pkg::MODE_ERASE, 5'd0, 32'h0, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_RANGE, 5'd0));
    add_row(pil_pkg::MODE_INSERT, 5'd1, 32'h1234, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_RANGE, 5'd0));
    add_row(pil_pkg::MODE_READ, 5'd31, 32'h0, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_RANGE, 5'd0));
    add_row(pil_pkg::MODE_INSERT, 5'd0, 32'hFFFF_FFFF, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_OK, 5'd1));
    add_row(pil_pkg::MODE_READ, 5'd0, 32'h0, 1, 1'b1,
            mk_result(32'hFFFF_FFFF, pil_pkg::ST_OK, 5'd1));
    add_row(pil_pkg::MODE_APPEND, 5'd0, 32'h0, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_OK, 5'd2));
    add_row(pil_pkg::MODE_INSERT, 5'd1, 32'hA5A5_A5A5, 1, 1'b0, none);
    add_row(pil_pkg::MODE_APPEND, 5'd0, 32'h8000_0001, 13, 1'b0, none);
    add_row(pil_pkg::MODE_APPEND, 5'd0, 32'h1, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_FULL, 5'd16));
    add_row(pil_pkg::MODE_INSERT, 5'd16, 32'h2, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_FULL, 5'd16));
    add_row(pil_pkg::MODE_INSERT, 5'd17, 32'h3, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_RANGE, 5'd16));
    add_row(pil_pkg::MODE_INSERT, 5'd0, 32'h4, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_FULL, 5'd16));
    add_row(pil_pkg::MODE_READ, 5'd15, 32'h0, 1, 1'b0, none);
    add_row(pil_pkg::MODE_READ, 5'd16, 32'h0, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_RANGE, 5'd16));
    add_row(pil_pkg::MODE_ERASE, 5'd16, 32'h0, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_RANGE, 5'd16));
    add_row(pil_pkg::MODE_ERASE, 5'd0, 32'h0, 1, 1'b0, none);
    add_row(pil_pkg::MODE_ERASE, 5'd14, 32'h0, 1, 1'b0, none);
    add_row(pil_pkg::MODE_READ, 5'd0, 32'h0, 1, 1'b0, none);
    add_row(MODE_SPARE6, 5'd3, 32'h5555_5555, 1, 1'b0, none);
    add_row(MODE_SPARE7, 5'd31, 32'hFFFF_FFFF, 1, 1'b0, none);
    add_row(pil_pkg::MODE_POP, 5'd0, 32'h0, 1, 1'b0, none);
    add_row(pil_pkg::MODE_INSERT, 5'd13, 32'hDEAD_BEEF, 1, 1'b0, none);
    add_row(pil_pkg::MODE_CLEAR, 5'd0, 32'h0, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_OK, 5'd0));
    add_row(pil_pkg::MODE_READ, 5'd0, 32'h0, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_RANGE, 5'd0));
    add_row(pil_pkg::MODE_POP, 5'd0, 32'h0, 1, 1'b1,
            mk_result(32'h0, pil_pkg::ST_UNDER, 5'd0));

    // Hold reset, release at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    foreach (plan[n]) begin
      row = plan[n];
      for (k = 0; k < row.reps; k++)
        offer_item(row.op, row.pos, row.word + k, row.typed, row.want);
    end

    // Random traffic; ignored modes do not advance the count
    rand_done = 0;
    while (rand_done < RAND_ITEMS) begin
      quiet_phase = (rand_done >= 600) && (rand_done < 800);
      if (rand_done == 1100) stall_req = 1'b1;
      op = pick_op((rand_done / 90) % 3);
      offer_item(op, pick_pos(), pick_word(), 1'b0, none);
      if (op != MODE_SPARE6 && op != MODE_SPARE7) rand_done++;
    end
    in_valid    = 1'b0;
    quiet_phase = 1'b0;

    // Drain outstanding results, then watch for strays
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items, checked %0d results.", items_taken, results_seen);
    $display("Refusals seen: %0d full, %0d out of range, %0d underflow.",
             full_hits, range_hits, under_hits);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
